// ===== src/rsi_pkg.sv =====
// Shared types and constants for the ray-sphere intersection unit.
// Used by rsi_front, rsi_sqrt_pipe and ray_sphere_intersect_unit; no dependencies.
package rsi_pkg;

  localparam int FRAC_BITS = 16;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_RADIUS   = 3'd3;
  localparam logic [2:0] REG_EPSILON  = 3'd4;

  localparam int B_W    = 37;  // b, floor of dot(v,d) to FRAC_BITS
  localparam int DISC_W = 70;  // disc and its remainders
  localparam int ROOT_W = 35;  // isqrt(disc)

  // Side data that rides along the square-root stages
  typedef struct packed {
    logic signed [B_W-1:0] b;
    logic                  miss;
    logic [30:0]           max_distance;
  } side_t;

endpackage

// ===== src/ray_sphere_intersect_unit.sv =====
// Ray-sphere intersection unit: top level with configuration registers and result stage.
// Depends on rsi_pkg, rsi_front and rsi_sqrt_pipe.
//
// Usage:
//   Rays enter on the in_ channel (valid/stall) and one result word leaves on the
//   out_ channel for every ray, in order: out_hit and out_t_hit (zero on a miss).
//   The sphere is set through cfg_we/cfg_index/cfg_data while the unit is idle;
//   indexes 0..4 are center x/y/z, radius and epsilon, others are ignored.
//   The word passes 41 registers, the first loaded at the accepting edge: five front
//   stages, 35 square-root stages (one root bit each) and the result register.
//   Throughput is one ray per cycle while the receiver does not stall a result.
//   When the receiver stalls a valid result, the whole pipeline holds and in_stall
//   rises in the same cycle; nothing is lost or repeated.
//   Reset clears all valid bits and loads center 0, radius 1.0 and epsilon 16.
module ray_sphere_intersect_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  input  logic [30:0]        in_max_distance,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [30:0]        out_t_hit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic signed [31:0] center_x_r, center_y_r, center_z_r;
  logic [30:0] radius_r;
  logic [15:0] epsilon_r;

  logic adv;
  logic f_valid, s_valid;
  logic [rsi_pkg::DISC_W-1:0] f_disc;
  rsi_pkg::side_t f_side, s_side;
  logic [rsi_pkg::ROOT_W-1:0] s_root;

  logic signed [38:0] t1, t2, t_sel, eps_s, md_s;
  logic miss;
  logic out_valid_r, out_hit_r;
  logic [30:0] out_t_hit_r;

  // Hold the pipeline while a result word waits
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= 31'd65536;
      epsilon_r  <= 16'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsi_pkg::REG_CENTER_X: center_x_r <= cfg_data;
        rsi_pkg::REG_CENTER_Y: center_y_r <= cfg_data;
        rsi_pkg::REG_CENTER_Z: center_z_r <= cfg_data;
        rsi_pkg::REG_RADIUS:   radius_r   <= cfg_data[30:0];
        rsi_pkg::REG_EPSILON:  epsilon_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rsi_front u_front (
    .clk, .rst_n, .adv,
    .in_valid,
    .origin_x(in_origin_x), .origin_y(in_origin_y), .origin_z(in_origin_z),
    .dir_x(in_dir_x), .dir_y(in_dir_y), .dir_z(in_dir_z),
    .max_distance(in_max_distance),
    .center_x(center_x_r), .center_y(center_y_r), .center_z(center_z_r),
    .radius(radius_r),
    .valid_o(f_valid), .disc_o(f_disc), .side_o(f_side)
  );

  rsi_sqrt_pipe u_sqrt (
    .clk, .rst_n, .adv,
    .valid_i(f_valid), .disc_i(f_disc), .side_i(f_side),
    .valid_o(s_valid), .root_o(s_root), .side_o(s_side)
  );

  // Pick the near root above epsilon, else the far one, and range check it
  assign t1    = 39'(s_side.b) - 39'({1'b0, s_root});
  assign t2    = 39'(s_side.b) + 39'({1'b0, s_root});
  assign eps_s = 39'({1'b0, epsilon_r});
  assign md_s  = 39'({1'b0, s_side.max_distance});
  assign t_sel = (t1 > eps_s) ? t1 : t2;
  assign miss  = s_side.miss || ((t1 < eps_s) && (t2 < eps_s)) || (t_sel > md_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r   <= !miss;
      out_t_hit_r <= miss ? '0 : t_sel[30:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_t_hit = out_t_hit_r;

  // Stall on the input comes only from a waiting result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  // A miss carries a zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_t_hit == 31'd0))
    else $error("miss with nonzero distance");

  // A hit is never closer than epsilon
  a_hit_eps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_t_hit >= 31'(epsilon_r)))
    else $error("hit closer than epsilon");

endmodule

// ===== src/rsi_front.sv =====
// Front stages: v = c - o, products, b and |v|^2, squares, discriminant.
// Depends on rsi_pkg.
module rsi_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  input  logic signed [31:0]                origin_x,
  input  logic signed [31:0]                origin_y,
  input  logic signed [31:0]                origin_z,
  input  logic signed [17:0]                dir_x,
  input  logic signed [17:0]                dir_y,
  input  logic signed [17:0]                dir_z,
  input  logic [30:0]                       max_distance,
  input  logic signed [31:0]                center_x,
  input  logic signed [31:0]                center_y,
  input  logic signed [31:0]                center_z,
  input  logic [30:0]                       radius,
  output logic                              valid_o,
  output logic [rsi_pkg::DISC_W-1:0]        disc_o,
  output rsi_pkg::side_t                    side_o
);

  // Stage 1: difference vector
  logic [3:0] vld_r;
  logic signed [32:0] vx_r, vy_r, vz_r;
  logic signed [17:0] dx_r, dy_r, dz_r;
  logic [30:0] md1_r, md2_r, md3_r, md4_r;

  // Stage 2: products
  logic signed [50:0] px_r, py_r, pz_r;
  logic [65:0] qx_r, qy_r, qz_r;

  // Stage 3: b and |v|^2
  logic signed [52:0] dot;
  logic signed [rsi_pkg::B_W-1:0] b3_r, b4_r;
  logic [67:0] vv3_r, vv4_r;

  // Stage 4: squares
  logic signed [73:0] bsq;
  logic [69:0] b2_r;
  logic [61:0] r2_r;

  // Stage 5: discriminant
  logic [69:0] pos;
  logic [rsi_pkg::DISC_W-1:0] disc_r;
  rsi_pkg::side_t side_r;
  logic vld5_r;

  assign dot = 53'(px_r) + 53'(py_r) + 53'(pz_r);
  assign bsq = b3_r * b3_r;
  assign pos = b2_r + 70'(r2_r);

  // Advance valid bits in step with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vld5_r <= 1'b0;
    end else if (adv) begin
      vld_r  <= {vld_r[2:0], in_valid};
      vld5_r <= vld_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx_r  <= 33'(center_x) - 33'(origin_x);
      vy_r  <= 33'(center_y) - 33'(origin_y);
      vz_r  <= 33'(center_z) - 33'(origin_z);
      dx_r  <= dir_x;
      dy_r  <= dir_y;
      dz_r  <= dir_z;
      md1_r <= max_distance;

      px_r  <= vx_r * 51'(dx_r);
      py_r  <= vy_r * 51'(dy_r);
      pz_r  <= vz_r * 51'(dz_r);
      qx_r  <= 66'(vx_r * vx_r);
      qy_r  <= 66'(vy_r * vy_r);
      qz_r  <= 66'(vz_r * vz_r);
      md2_r <= md1_r;

      b3_r  <= dot[rsi_pkg::FRAC_BITS+rsi_pkg::B_W-1:rsi_pkg::FRAC_BITS];
      vv3_r <= 68'(qx_r) + 68'(qy_r) + 68'(qz_r);
      md3_r <= md2_r;

      b2_r  <= bsq[69:0];
      r2_r  <= radius * radius;
      b4_r  <= b3_r;
      vv4_r <= vv3_r;
      md4_r <= md3_r;

      disc_r              <= pos - 70'(vv4_r);
      side_r.b            <= b4_r;
      side_r.miss         <= 70'(vv4_r) > pos;
      side_r.max_distance <= md4_r;
    end
  end

  assign valid_o = vld5_r;
  assign disc_o  = disc_r;
  assign side_o  = side_r;

endmodule

// ===== src/rsi_sqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, side data alongside.
// Depends on rsi_pkg.
module rsi_sqrt_pipe (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              valid_i,
  input  logic [rsi_pkg::DISC_W-1:0]        disc_i,
  input  rsi_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic [rsi_pkg::ROOT_W-1:0]        root_o,
  output rsi_pkg::side_t                    side_o
);

  localparam int N = rsi_pkg::ROOT_W;
  localparam int W = rsi_pkg::DISC_W;

  logic [W-1:0] x_r   [N+1];
  logic [W-1:0] res_r [N+1];
  rsi_pkg::side_t side_r [N+1];
  logic [N:0] vld_r;

  assign x_r[0]   = disc_i;
  assign res_r[0] = '0;
  assign side_r[0] = side_i;
  assign vld_r[0] = valid_i;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [W:0] BIT = (W+1)'(1) << (2 * (N - 1 - i));
    logic [W:0] trial;
    logic take;

    assign trial = {1'b0, res_r[i]} + BIT;
    assign take  = {1'b0, x_r[i]} >= trial;

    // Retire one root bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i+1]    <= take ? x_r[i] - trial[W-1:0] : x_r[i];
        res_r[i+1]  <= take ? (res_r[i] >> 1) + BIT[W-1:0] : res_r[i] >> 1;
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign valid_o = vld_r[N];
  assign root_o  = res_r[N][N-1:0];
  assign side_o  = side_r[N];

endmodule
